@@ rtl/gcio_pkg.sv @@
// Package for the game-console I/O interface: command types, codes, bit positions
// and the button tables shared by the front, queue and back modules.
// No dependencies.
`default_nettype none

package gcio_pkg;

	localparam int unsigned WORD_W   = 36;
	localparam int unsigned THRESH_W = 15;
	localparam int unsigned LEVEL_W  = 4;

	localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 15'd10000;

	// Depth of the command queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Input item modes.
	localparam logic [1:0] MODE_AXIS   = 2'd0;
	localparam logic [1:0] MODE_BUTTON = 2'd1;
	localparam logic [1:0] MODE_BUS    = 2'd2;

	// Device select codes.
	localparam logic [1:0] DEV_PRIMARY   = 2'd0;
	localparam logic [1:0] DEV_SECONDARY = 2'd1;

	// Axis numbers.
	localparam logic [2:0] AXIS_HORIZONTAL = 3'd0;
	localparam logic [2:0] AXIS_VERTICAL   = 3'd1;

	// Bus pulse bits, acted on in this order.
	localparam int unsigned PULSE_DATA_READ = 0;
	localparam int unsigned PULSE_CTL_CLEAR = 1;
	localparam int unsigned PULSE_CTL_SET   = 2;
	localparam int unsigned PULSE_DATA_CLR  = 3;
	localparam int unsigned PULSE_DATA_SET  = 4;

	// Control word enable bits.
	localparam int unsigned CTL_SWITCH_EN_BIT = 5;
	localparam int unsigned CTL_RED_EN_BIT    = 22;
	localparam int unsigned CTL_GREEN_EN_BIT  = 13;
	localparam int unsigned CTL_BLUE_EN_BIT   = 4;

	// Per-controller switch bits. Console fields are 9 bits wide and active low,
	// office fields are 18 bits wide and active high.
	localparam logic [8:0]  CON_AXIS_H     = 9'o600;
	localparam logic [8:0]  CON_AXIS_H_LO  = 9'o200;
	localparam logic [8:0]  CON_AXIS_H_HI  = 9'o400;
	localparam logic [8:0]  CON_AXIS_V     = 9'o100;
	localparam logic [17:0] OFF_AXIS_H     = 18'o60;
	localparam logic [17:0] OFF_AXIS_H_LO  = 18'o20;
	localparam logic [17:0] OFF_AXIS_H_HI  = 18'o40;
	localparam logic [17:0] OFF_AXIS_V     = 18'o300;
	localparam logic [17:0] OFF_AXIS_V_LO  = 18'o200;
	localparam logic [17:0] OFF_AXIS_V_HI  = 18'o100;

	typedef enum logic [1:0] {
		CMD_SWITCH    = 2'd0,
		CMD_PRIMARY   = 2'd1,
		CMD_SECONDARY = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [WORD_W-1:0]  con_set;
		logic [WORD_W-1:0]  con_clr;
		logic [WORD_W-1:0]  off_set;
		logic [WORD_W-1:0]  off_clr;
		logic [4:0]         pulses;
		logic [WORD_W-1:0]  bus_data;
	} cmd_t;

	function automatic logic [17:0] office_button_map(input logic [3:0] btn);
		logic [17:0] m;
		case (btn)
			4'd0:    m = 18'o000010;
			4'd1:    m = 18'o000004;
			4'd2:    m = 18'o020000;
			4'd3:    m = 18'o000001;
			4'd4:    m = 18'o000002;
			4'd5:    m = 18'o000400;
			4'd6:    m = 18'o010000;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [8:0] console_button_map(input logic [3:0] btn);
		logic [8:0] m;
		case (btn)
			4'd0:    m = 9'o020;
			4'd1:    m = 9'o040;
			default: m = '0;
		endcase
		return m;
	endfunction

	// Place a controller's console field at bit 9*c.
	function automatic logic [WORD_W-1:0] place_console(input logic [8:0] v,
			input logic [1:0] c);
		logic [WORD_W-1:0] w;
		case (c)
			2'd0:    w = {27'b0, v};
			2'd1:    w = {18'b0, v, 9'b0};
			2'd2:    w = {9'b0, v, 18'b0};
			default: w = {v, 27'b0};
		endcase
		return w;
	endfunction

	// Place a controller's office field at bit 18*c; controllers 2 and 3 do not fit.
	function automatic logic [WORD_W-1:0] place_office(input logic [17:0] v,
			input logic [1:0] c);
		logic [WORD_W-1:0] w;
		case (c)
			2'd0:    w = {18'b0, v};
			2'd1:    w = {v, 18'b0};
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ rtl/gcio_if.sv @@
// Channel interfaces of the game-console I/O interface: the event/bus request
// channel and the result channel. Depends on nothing.
`default_nettype none

interface gcio_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [1:0]         controller;
	logic [2:0]         axis_number;
	logic signed [15:0] axis_value;
	logic [3:0]         button_number;
	logic               button_pressed;
	logic [1:0]         device_select;
	logic [4:0]         bus_pulses;
	logic [35:0]        bus_data;

	modport source (
		output valid, mode, controller, axis_number, axis_value, button_number,
			button_pressed, device_select, bus_pulses, bus_data,
		input  ready
	);
	modport sink (
		input  valid, mode, controller, axis_number, axis_value, button_number,
			button_pressed, device_select, bus_pulses, bus_data,
		output ready
	);
endinterface

interface gcio_rsp_if;
	logic        valid;
	logic        ready;
	logic        read_valid;
	logic [35:0] read_data;
	logic        plot_valid;
	logic [31:0] plot_word;

	modport source (
		output valid, read_valid, read_data, plot_valid, plot_word,
		input  ready
	);
	modport sink (
		input  valid, read_valid, read_data, plot_valid, plot_word,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/gcio_front.sv @@
// Front end: holds the axis threshold and turns each request into a command
// of set/clear masks or a bus access. Depends on gcio_pkg.
`default_nettype none

module gcio_front #(
	parameter int NUM_CONTROLLERS = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [gcio_pkg::THRESH_W-1:0]   cfg_wdata,
	input  wire logic [1:0]                      mode,
	input  wire logic [1:0]                      controller,
	input  wire logic [2:0]                      axis_number,
	input  wire logic signed [15:0]              axis_value,
	input  wire logic [3:0]                      button_number,
	input  wire logic                            button_pressed,
	input  wire logic [1:0]                      device_select,
	input  wire logic [4:0]                      bus_pulses,
	input  wire logic [gcio_pkg::WORD_W-1:0]     bus_data,
	output gcio_pkg::cmd_t                       cmd
);

	logic [gcio_pkg::THRESH_W-1:0] axis_threshold_q;
	logic signed [16:0] value_ext;
	logic signed [16:0] thresh_ext;
	logic lo;
	logic hi;
	logic ctl_ok;
	logic [8:0]  con_set9;
	logic [8:0]  con_clr9;
	logic [17:0] off_set18;
	logic [17:0] off_clr18;
	logic [8:0]  btn_con;
	logic [17:0] btn_off;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_threshold_q <= gcio_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			axis_threshold_q <= cfg_wdata;
		end
	end

	always_comb begin
		value_ext  = {axis_value[15], axis_value};
		thresh_ext = {2'b00, axis_threshold_q};
		lo = value_ext < -thresh_ext;
		hi = value_ext > thresh_ext;
		ctl_ok = int'(controller) < NUM_CONTROLLERS;
		btn_con = gcio_pkg::console_button_map(button_number);
		btn_off = gcio_pkg::office_button_map(button_number);
	end

	// Per-controller field masks; the new word is (old & ~clr) | set.
	always_comb begin
		con_set9  = '0;
		con_clr9  = '0;
		off_set18 = '0;
		off_clr18 = '0;
		if (ctl_ok && mode == gcio_pkg::MODE_AXIS) begin
			case (axis_number)
				gcio_pkg::AXIS_HORIZONTAL: begin
					con_clr9  = (lo ? gcio_pkg::CON_AXIS_H_LO : 9'd0) |
						(hi ? gcio_pkg::CON_AXIS_H_HI : 9'd0);
					con_set9  = gcio_pkg::CON_AXIS_H & ~con_clr9;
					off_clr18 = gcio_pkg::OFF_AXIS_H;
					off_set18 = (lo ? gcio_pkg::OFF_AXIS_H_LO : 18'd0) |
						(hi ? gcio_pkg::OFF_AXIS_H_HI : 18'd0);
				end
				gcio_pkg::AXIS_VERTICAL: begin
					con_clr9  = (lo || hi) ? gcio_pkg::CON_AXIS_V : 9'd0;
					con_set9  = (lo || hi) ? 9'd0 : gcio_pkg::CON_AXIS_V;
					off_clr18 = gcio_pkg::OFF_AXIS_V;
					off_set18 = lo ? gcio_pkg::OFF_AXIS_V_LO :
						(hi ? gcio_pkg::OFF_AXIS_V_HI : 18'd0);
				end
				default: begin
				end
			endcase
		end else if (ctl_ok && mode == gcio_pkg::MODE_BUTTON) begin
			if (button_pressed) begin
				con_clr9  = btn_con;
				off_set18 = btn_off;
			end else begin
				con_set9  = btn_con;
				off_clr18 = btn_off;
			end
		end
	end

	always_comb begin
		cmd = '0;
		cmd.kind     = gcio_pkg::CMD_SWITCH;
		cmd.con_set  = gcio_pkg::place_console(con_set9, controller);
		cmd.con_clr  = gcio_pkg::place_console(con_clr9, controller);
		cmd.off_set  = gcio_pkg::place_office(off_set18, controller);
		cmd.off_clr  = gcio_pkg::place_office(off_clr18, controller);
		cmd.pulses   = bus_pulses;
		cmd.bus_data = bus_data;
		if (mode == gcio_pkg::MODE_BUS) begin
			unique case (device_select)
				gcio_pkg::DEV_PRIMARY:   cmd.kind = gcio_pkg::CMD_PRIMARY;
				gcio_pkg::DEV_SECONDARY: cmd.kind = gcio_pkg::CMD_SECONDARY;
				default:                 cmd.kind = gcio_pkg::CMD_SWITCH;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/gcio_queue.sv @@
// Short command queue between front and back, so that each side stalls on its own.
// Depends on gcio_pkg.
`default_nettype none

module gcio_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  wire gcio_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  wire logic     pop_ready,
	output gcio_pkg::cmd_t pop_data
);

	localparam int unsigned PTR_W = (gcio_pkg::QUEUE_DEPTH > 1) ?
		$clog2(gcio_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(gcio_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(gcio_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(gcio_pkg::QUEUE_DEPTH);

	gcio_pkg::cmd_t entries_q [gcio_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != FULL_CNT;
	assign pop_valid  = count_q != '0;
	assign pop_data   = entries_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("command queue count exceeds its depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("command queue empty with unequal pointers");

endmodule

`default_nettype wire

@@ rtl/gcio_back.sv @@
// Back end: holds the switch words, control and data words and colour levels,
// carries out commands and registers one result per command. Depends on gcio_pkg.
`default_nettype none

module gcio_back (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_ready,
	input  wire gcio_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output logic           read_valid,
	output logic [35:0]    read_data,
	output logic           plot_valid,
	output logic [31:0]    plot_word
);

	localparam int unsigned W = gcio_pkg::WORD_W;
	localparam int unsigned LW = gcio_pkg::LEVEL_W;

	logic [W-1:0]  console_q;
	logic [W-1:0]  office_q;
	logic [W-1:0]  control_q;
	logic [W-1:0]  data_q;
	logic [LW-1:0] red_q;
	logic [LW-1:0] green_q;
	logic [LW-1:0] blue_q;
	logic          rsp_valid_q;
	logic          read_valid_q;
	logic [W-1:0]  read_data_q;
	logic          plot_valid_q;
	logic [31:0]   plot_word_q;

	logic          take;
	logic [W-1:0]  console_n;
	logic [W-1:0]  office_n;
	logic [W-1:0]  control_n;
	logic [W-1:0]  data_n;
	logic [LW-1:0] red_n;
	logic [LW-1:0] green_n;
	logic [LW-1:0] blue_n;
	logic          rv_n;
	logic [W-1:0]  rd_n;
	logic          pv_n;
	logic [31:0]   pw_n;

	assign cmd_ready  = !rsp_valid_q || rsp_ready;
	assign take       = cmd_valid && cmd_ready;
	assign rsp_valid  = rsp_valid_q;
	assign read_valid = read_valid_q;
	assign read_data  = read_data_q;
	assign plot_valid = plot_valid_q;
	assign plot_word  = plot_word_q;

	always_comb begin
		console_n = (console_q & ~cmd.con_clr) | cmd.con_set;
		office_n  = (office_q & ~cmd.off_clr) | cmd.off_set;
		control_n = control_q;
		data_n    = data_q;
		red_n     = red_q;
		green_n   = green_q;
		blue_n    = blue_q;
		rv_n      = 1'b0;
		rd_n      = '0;
		pv_n      = 1'b0;
		pw_n      = '0;
		unique case (cmd.kind)
			gcio_pkg::CMD_PRIMARY: begin
				console_n = console_q;
				office_n  = office_q;
				if (cmd.pulses[gcio_pkg::PULSE_DATA_READ]) begin
					rv_n = 1'b1;
					rd_n = control_q[gcio_pkg::CTL_SWITCH_EN_BIT] ? console_q : '0;
				end
				if (cmd.pulses[gcio_pkg::PULSE_CTL_CLEAR]) begin
					control_n = '0;
				end
				if (cmd.pulses[gcio_pkg::PULSE_CTL_SET]) begin
					control_n = control_n | cmd.bus_data;
					// On a control set, each colour level reloads if its enable bit is set.
					if (control_n[gcio_pkg::CTL_RED_EN_BIT]) begin
						red_n = control_n[15:12];
					end
					if (control_n[gcio_pkg::CTL_GREEN_EN_BIT]) begin
						green_n = control_n[9:6];
					end
					if (control_n[gcio_pkg::CTL_BLUE_EN_BIT]) begin
						blue_n = control_n[3:0];
					end
				end
				if (cmd.pulses[gcio_pkg::PULSE_DATA_CLR]) begin
					data_n = '0;
				end
				if (cmd.pulses[gcio_pkg::PULSE_DATA_SET]) begin
					data_n = data_n | cmd.bus_data;
					pv_n = 1'b1;
					pw_n = {red_n, green_n, blue_n, 1'b0, data_n[8:0], 1'b0, data_n[17:9]};
				end
			end
			gcio_pkg::CMD_SECONDARY: begin
				console_n = console_q;
				office_n  = office_q;
				if (cmd.pulses[gcio_pkg::PULSE_DATA_READ]) begin
					rv_n = 1'b1;
					rd_n = office_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			console_q   <= '1;
			office_q    <= '0;
			control_q   <= '0;
			data_q      <= '0;
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				console_q <= console_n;
				office_q  <= office_n;
				control_q <= control_n;
				data_q    <= data_n;
				red_q     <= red_n;
				green_q   <= green_n;
				blue_q    <= blue_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			read_valid_q <= rv_n;
			read_data_q  <= rd_n;
			plot_valid_q <= pv_n;
			plot_word_q  <= pw_n;
		end
	end

	a_state_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> ($stable(console_q) && $stable(office_q) &&
			$stable(control_q) && $stable(data_q)))
		else $error("state changed while a result was stalled");

	a_read_data_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !read_valid_q) |-> (read_data_q == '0))
		else $error("read data without a read");

	a_plot_word_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !plot_valid_q) |-> (plot_word_q == '0))
		else $error("plot word without a data set");

endmodule

`default_nettype wire

@@ rtl/game_console_io_interface_core.sv @@
// Top level of the game-console I/O interface: front end, command queue, back end.
// Depends on gcio_pkg, gcio_if, gcio_front, gcio_queue and gcio_back.
//
//   Channel  Direction  Handshake        Carries
//   req      in         valid/ready      axis, button or bus access item
//   rsp      out        valid/ready      read_valid, read_data, plot_valid, plot_word
//   cfg      in         cfg_we only      axis_threshold (15 bits)
//
// Every accepted item gives exactly one result. The item enters the queue at the
// accepting edge; the back end registers its result when it takes the item from
// the queue, which older queued items or a stalled result register can delay.
// One item per clock is taken in steady flow while rsp.ready stays high; the back
// end, updating the switch, control and data words for each command, sets that rate.
// While the result register is stalled, the two-entry command queue keeps taking
// items until it is full; req.ready then drops.
// arst_n resets all but the queue entries and result fields at once; there is no clearing pass.
`default_nettype none

module game_console_io_interface_core #(
	parameter int NUM_CONTROLLERS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gcio_pkg::THRESH_W-1:0] cfg_wdata,
	gcio_req_if.sink                           req,
	gcio_rsp_if.source                         rsp
);

	gcio_pkg::cmd_t front_cmd;
	gcio_pkg::cmd_t back_cmd;
	logic           back_valid;
	logic           back_ready;

	gcio_front #(
		.NUM_CONTROLLERS(NUM_CONTROLLERS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mode           (req.mode),
		.controller     (req.controller),
		.axis_number    (req.axis_number),
		.axis_value     (req.axis_value),
		.button_number  (req.button_number),
		.button_pressed (req.button_pressed),
		.device_select  (req.device_select),
		.bus_pulses     (req.bus_pulses),
		.bus_data       (req.bus_data),
		.cmd            (front_cmd)
	);

	gcio_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (req.valid),
		.push_ready (req.ready),
		.push_data  (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cmd)
	);

	gcio_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (back_valid),
		.cmd_ready  (back_ready),
		.cmd        (back_cmd),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.read_valid (rsp.read_valid),
		.read_data  (rsp.read_data),
		.plot_valid (rsp.plot_valid),
		.plot_word  (rsp.plot_word)
	);

endmodule

`default_nettype wire

@@ tb/game_console_io_interface_core_tb.sv @@
// Self-checking testbench for game_console_io_interface_core: axis, button and bus
// transactions are predicted by a scoreboard class and checked reply by reply.
// Depends on gcio_pkg, gcio_if and the RTL of the core.
`default_nettype none

module game_console_io_interface_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CTRL = 4;
	localparam int STALL_LIMIT = 3000;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] DEV_NONE    = 2'd2;

	localparam logic [4:0] P_READ    = 5'b1 << gcio_pkg::PULSE_DATA_READ;
	localparam logic [4:0] P_CTL_CLR = 5'b1 << gcio_pkg::PULSE_CTL_CLEAR;
	localparam logic [4:0] P_CTL_SET = 5'b1 << gcio_pkg::PULSE_CTL_SET;
	localparam logic [4:0] P_DAT_CLR = 5'b1 << gcio_pkg::PULSE_DATA_CLR;
	localparam logic [4:0] P_DAT_SET = 5'b1 << gcio_pkg::PULSE_DATA_SET;
	localparam logic [4:0] P_ALL     = 5'b11111;

	localparam logic [35:0] ALL_ONES = {36{1'b1}};

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  controller;
		logic [2:0]  axis_number;
		logic [15:0] axis_value;
		logic [3:0]  button_number;
		logic        button_pressed;
		logic [1:0]  device_select;
		logic [4:0]  bus_pulses;
		logic [35:0] bus_data;
	} gc_event_t;

	typedef struct packed {
		logic        read_valid;
		logic [35:0] read_data;
		logic        plot_valid;
		logic [31:0] plot_word;
	} bus_reply_t;

	class io_word_scoreboard;
		logic [14:0] threshold;
		logic [35:0] console_sw;
		logic [35:0] office_sw;
		logic [35:0] control_w;
		logic [35:0] data_w;
		logic [3:0]  red;
		logic [3:0]  green;
		logic [3:0]  blue;
		bus_reply_t  expected_replies[$];
		int          failures;

		function new();
			threshold  = gcio_pkg::THRESHOLD_RESET;
			console_sw = ALL_ONES;
			office_sw  = '0;
			control_w  = '0;
			data_w     = '0;
			red        = '0;
			green      = '0;
			blue       = '0;
			failures   = 0;
		endfunction

		function logic [35:0] con_field(input logic [8:0] v, input logic [1:0] c);
			return 36'(v) << (9 * c);
		endfunction

		// Office fields are 18 bits per controller, so only controllers 0 and 1 fit.
		function logic [35:0] off_field(input logic [17:0] v, input logic [1:0] c);
			if (c >= 2)
				return '0;
			return 36'(v) << (18 * c);
		endfunction

		function void note_event(input gc_event_t ev);
			bus_reply_t  r;
			int          t;
			int          v;
			bit          lo;
			bit          hi;
			logic [17:0] ox;
			logic [8:0]  cy;
			logic [4:0]  p;
			r  = '0;
			t  = int'(threshold);
			v  = int'($signed(ev.axis_value));
			lo = v < -t;
			hi = v > t;
			p  = ev.bus_pulses;
			if (ev.mode == gcio_pkg::MODE_AXIS && ev.controller < NUM_CTRL) begin
				if (ev.axis_number == gcio_pkg::AXIS_HORIZONTAL) begin
					console_sw |= con_field(gcio_pkg::CON_AXIS_H, ev.controller);
					if (lo)
						console_sw &= ~con_field(gcio_pkg::CON_AXIS_H_LO, ev.controller);
					if (hi)
						console_sw &= ~con_field(gcio_pkg::CON_AXIS_H_HI, ev.controller);
					office_sw &= ~off_field(gcio_pkg::OFF_AXIS_H, ev.controller);
					if (lo)
						office_sw |= off_field(gcio_pkg::OFF_AXIS_H_LO, ev.controller);
					if (hi)
						office_sw |= off_field(gcio_pkg::OFF_AXIS_H_HI, ev.controller);
				end else if (ev.axis_number == gcio_pkg::AXIS_VERTICAL) begin
					console_sw |= con_field(gcio_pkg::CON_AXIS_V, ev.controller);
					office_sw &= ~off_field(gcio_pkg::OFF_AXIS_V, ev.controller);
					if (lo) begin
						console_sw &= ~con_field(gcio_pkg::CON_AXIS_V, ev.controller);
						office_sw |= off_field(gcio_pkg::OFF_AXIS_V_LO, ev.controller);
					end else if (hi) begin
						console_sw &= ~con_field(gcio_pkg::CON_AXIS_V, ev.controller);
						office_sw |= off_field(gcio_pkg::OFF_AXIS_V_HI, ev.controller);
					end
				end
			end else if (ev.mode == gcio_pkg::MODE_BUTTON && ev.controller < NUM_CTRL) begin
				case (ev.button_number)
					4'd0:    begin ox = 18'o000010; cy = 9'o020; end
					4'd1:    begin ox = 18'o000004; cy = 9'o040; end
					4'd2:    begin ox = 18'o020000; cy = '0; end
					4'd3:    begin ox = 18'o000001; cy = '0; end
					4'd4:    begin ox = 18'o000002; cy = '0; end
					4'd5:    begin ox = 18'o000400; cy = '0; end
					4'd6:    begin ox = 18'o010000; cy = '0; end
					default: begin ox = '0; cy = '0; end
				endcase
				if (ev.button_pressed) begin
					console_sw &= ~con_field(cy, ev.controller);
					office_sw |= off_field(ox, ev.controller);
				end else begin
					console_sw |= con_field(cy, ev.controller);
					office_sw &= ~off_field(ox, ev.controller);
				end
			end else if (ev.mode == gcio_pkg::MODE_BUS &&
					ev.device_select == gcio_pkg::DEV_PRIMARY) begin
				if (p[gcio_pkg::PULSE_DATA_READ]) begin
					r.read_valid = 1'b1;
					if (control_w[gcio_pkg::CTL_SWITCH_EN_BIT])
						r.read_data = console_sw;
				end
				if (p[gcio_pkg::PULSE_CTL_CLEAR])
					control_w = '0;
				if (p[gcio_pkg::PULSE_CTL_SET]) begin
					control_w |= ev.bus_data;
					if (control_w[gcio_pkg::CTL_RED_EN_BIT])
						red = control_w[15:12];
					if (control_w[gcio_pkg::CTL_GREEN_EN_BIT])
						green = control_w[9:6];
					if (control_w[gcio_pkg::CTL_BLUE_EN_BIT])
						blue = control_w[3:0];
				end
				if (p[gcio_pkg::PULSE_DATA_CLR])
					data_w = '0;
				if (p[gcio_pkg::PULSE_DATA_SET]) begin
					data_w |= ev.bus_data;
					r.plot_valid = 1'b1;
					// y sits at bit 10 and x at bit 0, with a zero bit above each.
					r.plot_word = {red, green, blue, 1'b0, data_w[8:0], 1'b0, data_w[17:9]};
				end
			end else if (ev.mode == gcio_pkg::MODE_BUS &&
					ev.device_select == gcio_pkg::DEV_SECONDARY) begin
				if (p[gcio_pkg::PULSE_DATA_READ]) begin
					r.read_valid = 1'b1;
					r.read_data  = office_sw;
				end
			end
			expected_replies.push_back(r);
		endfunction

		function void check_reply(input bus_reply_t got);
			bus_reply_t want;
			if (expected_replies.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("[%0t] reply with none expected: rv=%0b rd=%o pv=%0b pw=%h",
						$realtime, got.read_valid, got.read_data, got.plot_valid,
						got.plot_word);
				return;
			end
			want = expected_replies.pop_front();
			if (got.read_valid !== want.read_valid || got.read_data !== want.read_data ||
					got.plot_valid !== want.plot_valid || got.plot_word !== want.plot_word) begin
				failures++;
				if (failures <= 10)
					$display({"[%0t] reply mismatch: exp rv=%0b rd=%o pv=%0b pw=%h, ",
						"got rv=%0b rd=%o pv=%0b pw=%h"},
						$realtime, want.read_valid, want.read_data, want.plot_valid,
						want.plot_word, got.read_valid, got.read_data, got.plot_valid,
						got.plot_word);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [14:0] cfg_wdata;

	gcio_req_if req_ch();
	gcio_rsp_if rsp_ch();

	game_console_io_interface_core #(.NUM_CONTROLLERS(NUM_CTRL)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	io_word_scoreboard sb;
	int                tx_idle_pct = 16;
	int                rx_idle_pct = 16;
	int                quiet_cycles = 0;
	gc_event_t         directed[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Sampling point for the scoreboard and the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.threshold = cfg_wdata;
			if (req_ch.valid && req_ch.ready)
				sb.note_event('{req_ch.mode, req_ch.controller, req_ch.axis_number,
					req_ch.axis_value, req_ch.button_number, req_ch.button_pressed,
					req_ch.device_select, req_ch.bus_pulses, req_ch.bus_data});
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_reply('{rsp_ch.read_valid, rsp_ch.read_data, rsp_ch.plot_valid,
					rsp_ch.plot_word});
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[game_console_io_interface_core] ERROR");
				$finish;
			end
		end
	end

	function automatic gc_event_t mk(input logic [1:0] mode, input logic [1:0] ctl,
			input logic [2:0] axis, input int val, input logic [3:0] btn,
			input logic pressed, input logic [1:0] dev, input logic [4:0] pulses,
			input logic [35:0] data);
		gc_event_t ev;
		ev.mode           = mode;
		ev.controller     = ctl;
		ev.axis_number    = axis;
		ev.axis_value     = val[15:0];
		ev.button_number  = btn;
		ev.button_pressed = pressed;
		ev.device_select  = dev;
		ev.bus_pulses     = pulses;
		ev.bus_data       = data;
		return ev;
	endfunction

	function automatic gc_event_t random_event(input logic [14:0] thr);
		gc_event_t   ev;
		logic [63:0] wide;
		int          pick;
		int          t;
		int          v;
		t    = int'(thr);
		pick = $urandom_range(99);
		ev.mode = (pick < 35) ? gcio_pkg::MODE_AXIS : (pick < 60) ? gcio_pkg::MODE_BUTTON :
			(pick < 97) ? gcio_pkg::MODE_BUS : MODE_UNUSED;
		ev.controller  = 2'($urandom_range(3));
		ev.axis_number = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) :
			3'($urandom_range(1));
		// Values cluster around both thresholds so that the comparisons are exercised.
		case ($urandom_range(3))
			0:       v = int'($urandom_range(65535));
			1:       v = t + int'($urandom_range(2)) - 1;
			2:       v = -t + int'($urandom_range(2)) - 1;
			default: v = $urandom_range(1) ? 32767 : -32768;
		endcase
		ev.axis_value     = v[15:0];
		ev.button_number  = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) :
			4'($urandom_range(6));
		ev.button_pressed = 1'($urandom_range(1));
		pick = $urandom_range(99);
		ev.device_select = (pick < 50) ? gcio_pkg::DEV_PRIMARY :
			(pick < 88) ? gcio_pkg::DEV_SECONDARY : 2'($urandom_range(3, 2));
		ev.bus_pulses = 5'($urandom_range(31));
		wide = {$urandom(), $urandom()};
		ev.bus_data = wide[35:0];
		return ev;
	endfunction

	task automatic send_event(input gc_event_t ev);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.mode           <= ev.mode;
		req_ch.controller     <= ev.controller;
		req_ch.axis_number    <= ev.axis_number;
		req_ch.axis_value     <= ev.axis_value;
		req_ch.button_number  <= ev.button_number;
		req_ch.button_pressed <= ev.button_pressed;
		req_ch.device_select  <= ev.device_select;
		req_ch.bus_pulses     <= ev.bus_pulses;
		req_ch.bus_data       <= ev.bus_data;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// The sender stops until every outstanding reply is back, then the block idles.
	task automatic drain_replies();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.expected_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [14:0] value);
		drain_replies();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_random(input int count);
		repeat (count) send_event(random_event(sb.threshold));
	endtask

	initial begin
		sb = new();
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		req_ch.valid          = 1'b0;
		req_ch.mode           = '0;
		req_ch.controller     = '0;
		req_ch.axis_number    = '0;
		req_ch.axis_value     = '0;
		req_ch.button_number  = '0;
		req_ch.button_pressed = 1'b0;
		req_ch.device_select  = '0;
		req_ch.bus_pulses     = '0;
		req_ch.bus_data       = '0;
		rsp_ch.ready          = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reads before and after the switch enable, with all three colour latches loaded.
		directed.push_back(mk(gcio_pkg::MODE_BUS, 0, 0, 0, 0, 0, gcio_pkg::DEV_PRIMARY,
			P_READ, '0));
		directed.push_back(mk(gcio_pkg::MODE_BUS, 0, 0, 0, 0, 0, gcio_pkg::DEV_PRIMARY,
			P_CTL_SET,
			(36'd1 << gcio_pkg::CTL_RED_EN_BIT) | (36'd1 << gcio_pkg::CTL_GREEN_EN_BIT) |
			(36'd1 << gcio_pkg::CTL_SWITCH_EN_BIT) | (36'd1 << gcio_pkg::CTL_BLUE_EN_BIT) |
			(36'd15 << 12) | (36'd10 << 6) | 36'd5));
		directed.push_back(mk(gcio_pkg::MODE_BUS, 0, 0, 0, 0, 0, gcio_pkg::DEV_PRIMARY,
			P_READ, '0));
		directed.push_back(mk(gcio_pkg::MODE_AXIS, 0, gcio_pkg::AXIS_HORIZONTAL, -32768,
			0, 0, 0, 0, '0));
		directed.push_back(mk(gcio_pkg::MODE_AXIS, 1, gcio_pkg::AXIS_HORIZONTAL, 32767,
			0, 0, 0, 0, '0));
		directed.push_back(mk(gcio_pkg::MODE_AXIS, 2, gcio_pkg::AXIS_VERTICAL, -10001,
			0, 0, 0, 0, '0));
		directed.push_back(mk(gcio_pkg::MODE_AXIS, 3, gcio_pkg::AXIS_VERTICAL, 10001,
			0, 0, 0, 0, '0));
		directed.push_back(mk(gcio_pkg::MODE_AXIS, 0, gcio_pkg::AXIS_VERTICAL, 10000,
			0, 0, 0, 0, '0));
		directed.push_back(mk(gcio_pkg::MODE_AXIS, 1, gcio_pkg::AXIS_HORIZONTAL, -10000,
			0, 0, 0, 0, '0));
		directed.push_back(mk(gcio_pkg::MODE_AXIS, 2, 3'd7, -32768, 15, 1, 3, P_ALL,
			ALL_ONES));
		for (int b = 0; b < 7; b++)
			directed.push_back(mk(gcio_pkg::MODE_BUTTON, 1, 0, 0, 4'(b), 1, 0, 0, '0));
		directed.push_back(mk(gcio_pkg::MODE_BUTTON, 3, 0, 0, 1, 1, 0, 0, '0));
		directed.push_back(mk(gcio_pkg::MODE_BUTTON, 0, 0, 0, 15, 1, 0, 0, '0));
		directed.push_back(mk(gcio_pkg::MODE_BUTTON, 1, 0, 0, 2, 0, 0, 0, '0));
		directed.push_back(mk(gcio_pkg::MODE_BUS, 0, 0, 0, 0, 0, gcio_pkg::DEV_SECONDARY,
			P_ALL, ALL_ONES));
		directed.push_back(mk(gcio_pkg::MODE_BUS, 0, 0, 0, 0, 0, DEV_NONE, P_ALL,
			ALL_ONES));
		directed.push_back(mk(MODE_UNUSED, 3, 7, -1, 15, 1, gcio_pkg::DEV_PRIMARY, P_ALL,
			ALL_ONES));
		directed.push_back(mk(gcio_pkg::MODE_BUS, 0, 0, 0, 0, 0, gcio_pkg::DEV_PRIMARY,
			P_DAT_SET, ALL_ONES));
		directed.push_back(mk(gcio_pkg::MODE_BUS, 0, 0, 0, 0, 0, gcio_pkg::DEV_PRIMARY,
			P_ALL, 36'o123456712345));
		directed.push_back(mk(gcio_pkg::MODE_BUS, 0, 0, 0, 0, 0, gcio_pkg::DEV_PRIMARY,
			P_CTL_CLR | P_DAT_CLR | P_READ, '0));
		foreach (directed[i])
			send_event(directed[i]);

		write_threshold(15'd0);
		run_random(200);
		write_threshold(15'd32767);
		// A long stretch with both sides running flat out.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(200);
		tx_idle_pct = 16;
		rx_idle_pct = 16;
		write_threshold(15'($urandom_range(32767)));
		run_random(200);
		write_threshold(15'd1);
		run_random(150);
		write_threshold(15'($urandom_range(20000, 5000)));
		run_random(250);

		drain_replies();
		repeat (8) @(negedge clk);
		if (sb.failures == 0 && sb.expected_replies.size() == 0) begin
			$display("[game_console_io_interface_core] OK");
		end else begin
			$display("[game_console_io_interface_core] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
